@@ design/srx_pkg.sv @@
// Shared types, constants and helpers for the serial frame receiver.
package srx_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 5;
    localparam int IDX_W       = 4;
    localparam int BANKS       = 2;
    localparam int BANK_W      = 1;
    localparam int MAX_PAYLOAD = 16;
    localparam int RAM_DEPTH   = BANKS * MAX_PAYLOAD;
    localparam int RAM_AW      = BANK_W + IDX_W;
    localparam int CFG_IDX_W   = 8;

    localparam logic [LEN_W-1:0]  PAYLOAD_CAP = LEN_W'(MAX_PAYLOAD);
    localparam logic [BYTE_W-1:0] SUM_BASE    = 8'hFC;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE1  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE2  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd3;

    // configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_RST  = 8'hFC;
    localparam logic [BYTE_W-1:0] PRE1_RST  = 8'h02;
    localparam logic [BYTE_W-1:0] PRE2_RST  = 8'h7A;
    localparam logic [LEN_W-1:0]  LIMIT_RST = 5'd16;

    // packet type codes
    localparam logic [BYTE_W-1:0] TYPE_A0 = 8'h41;
    localparam logic [BYTE_W-1:0] TYPE_A1 = 8'h61;
    localparam logic [BYTE_W-1:0] TYPE_B0 = 8'h42;
    localparam logic [BYTE_W-1:0] TYPE_B1 = 8'h62;
    localparam logic [BYTE_W-1:0] TYPE_C0 = 8'h5A;
    localparam logic [BYTE_W-1:0] TYPE_C1 = 8'h7A;
    localparam logic [BYTE_W-1:0] TYPE_D0 = 8'h5B;
    localparam logic [BYTE_W-1:0] TYPE_D1 = 8'h7B;

    typedef enum logic [2:0] {
        F_SYNC,
        F_TYPE,
        F_PRE1,
        F_PRE2,
        F_LEN,
        F_DATA,
        F_CSUM
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_FETCH,
        B_SHOW
    } t_back_state;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] preamble_first;
        logic [BYTE_W-1:0] preamble_second;
        logic [LEN_W-1:0]  payload_limit;
    } t_cfg;

    // one checked frame waiting for release
    typedef struct packed {
        logic [BYTE_W-1:0] ftype;
        logic [LEN_W-1:0]  flen;
        logic [BANK_W-1:0] bank;
    } t_frame_desc;

    // back part tells the front that a bank is drained
    typedef struct packed {
        logic              done;
        logic [BANK_W-1:0] bank;
    } t_back_status;

    function automatic logic type_known(input logic [BYTE_W-1:0] t);
        return t inside {TYPE_A0, TYPE_A1, TYPE_B0, TYPE_B1,
                         TYPE_C0, TYPE_C1, TYPE_D0, TYPE_D1};
    endfunction

endpackage

@@ design/srx_ram.sv @@
// Generic simple dual-port RAM with registered read.
module srx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/srx_queue.sv @@
// Two-entry descriptor queue between the frame parser and the release stage.
module srx_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  srx_pkg::t_frame_desc i_desc,
    output logic                 o_full,
    input  logic                 i_pop,
    output srx_pkg::t_frame_desc o_desc,
    output logic                 o_empty
);
    import srx_pkg::*;

    t_frame_desc r_slot [BANKS];
    logic [BANK_W-1:0] r_wr;
    logic [BANK_W-1:0] r_rd;
    logic [BANK_W:0]   r_count;

    assign o_full  = (r_count == (BANK_W+1)'(BANKS));
    assign o_empty = (r_count == '0);
    assign o_desc  = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_desc;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (BANK_W+1)'(BANKS)) else $error("queue count out of range");

endmodule

@@ design/srx_front.sv @@
// Frame parser: header checks, payload store writes, checksum, descriptor push.
module srx_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srx_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [srx_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_we,
    output logic [srx_pkg::RAM_AW-1:0]    o_waddr,
    output logic [srx_pkg::BYTE_W-1:0]    o_wdata,
    output logic                          o_push,
    output srx_pkg::t_frame_desc          o_desc,
    input  logic                          i_full,
    input  srx_pkg::t_back_status         i_back
);
    import srx_pkg::*;

    t_front_state r_state, n_state;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [BANK_W-1:0] r_wbank, n_wbank;
    logic [BANKS-1:0]  r_busy, n_busy;

    logic              accept;
    logic [LEN_W-1:0]  limit;
    logic [BYTE_W-1:0] c;

    // take bytes only while the bank being filled is free
    assign o_ready = !r_busy[r_wbank] && !i_full;
    assign accept  = i_valid && o_ready;
    assign c       = i_rx_byte;
    assign limit   = (i_cfg.payload_limit > PAYLOAD_CAP) ? PAYLOAD_CAP
                                                         : i_cfg.payload_limit;
    assign o_waddr = {r_wbank, r_cnt};
    assign o_wdata = c;
    assign o_desc  = '{ftype: r_type, flen: r_len, bank: r_wbank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_SYNC;
            r_wbank <= '0;
            r_busy  <= '0;
        end else begin
            r_state <= n_state;
            r_wbank <= n_wbank;
            r_busy  <= n_busy;
        end
        r_sum  <= n_sum;
        r_type <= n_type;
        r_len  <= n_len;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_type  = r_type;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_wbank = r_wbank;
        n_busy  = r_busy;
        o_we    = 1'b0;
        o_push  = 1'b0;

        if (i_back.done) begin
            n_busy[i_back.bank] = 1'b0;
        end

        if (accept) begin
            case (r_state)
                F_SYNC: begin
                    if (c == i_cfg.sync_value) begin
                        n_sum   = c;
                        n_state = F_TYPE;
                    end
                end
                F_TYPE: begin
                    if (type_known(c)) begin
                        n_type  = c;
                        n_sum   = r_sum + c;
                        n_state = F_PRE1;
                    end else begin
                        n_state = F_SYNC;
                    end
                end
                F_PRE1: begin
                    n_sum   = r_sum + c;
                    n_state = (c == i_cfg.preamble_first) ? F_PRE2 : F_SYNC;
                end
                F_PRE2: begin
                    n_sum   = r_sum + c;
                    n_state = (c == i_cfg.preamble_second) ? F_LEN : F_SYNC;
                end
                F_LEN: begin
                    if (c > {{(BYTE_W-LEN_W){1'b0}}, limit}) begin
                        n_state = F_SYNC;
                    end else begin
                        n_len   = c[LEN_W-1:0];
                        n_sum   = r_sum + c;
                        n_cnt   = '0;
                        n_state = (c == '0) ? F_CSUM : F_DATA;
                    end
                end
                F_DATA: begin
                    o_we  = 1'b1;
                    n_sum = r_sum + c;
                    n_cnt = r_cnt + 1'b1;
                    if ({1'b0, r_cnt} + 1'b1 == r_len) begin
                        n_state = F_CSUM;
                    end
                end
                F_CSUM: begin
                    n_state = F_SYNC;
                    if (c == SUM_BASE - r_sum) begin
                        o_push           = 1'b1;
                        n_busy[r_wbank]  = 1'b1;
                        n_wbank          = r_wbank + 1'b1;
                    end
                end
                default: n_state = F_SYNC;
            endcase
        end
    end

    a_write_free_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> !r_busy[r_wbank]) else $error("payload write into busy bank");
    a_push_marks_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_busy[$past(r_wbank)] && (r_wbank != $past(r_wbank)))
        else $error("pushed bank not held");
    a_release_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_back.done |-> r_busy[i_back.bank]) else $error("release of idle bank");

endmodule

@@ design/srx_back.sv @@
// Release stage: reads a checked frame from the store and emits one result per payload byte, or one for an empty frame.
module srx_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srx_pkg::t_frame_desc          i_desc,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_re,
    output logic [srx_pkg::RAM_AW-1:0]    o_raddr,
    input  logic [srx_pkg::BYTE_W-1:0]    i_rdata,
    output srx_pkg::t_back_status         o_status,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [srx_pkg::BYTE_W-1:0]    o_frame_type,
    output logic [srx_pkg::LEN_W-1:0]     o_frame_length,
    output logic [srx_pkg::IDX_W-1:0]     o_byte_index,
    output logic [srx_pkg::BYTE_W-1:0]    o_data_byte,
    output logic                          o_has_data,
    output logic                          o_last
);
    import srx_pkg::*;

    t_back_state r_state, n_state;
    t_frame_desc r_desc, n_desc;
    logic [IDX_W-1:0] r_idx, n_idx;

    logic has_data;
    logic last;

    assign has_data       = (r_desc.flen != '0);
    assign last           = !has_data || ({1'b0, r_idx} + 1'b1 == r_desc.flen);
    assign o_raddr        = {r_desc.bank, r_idx};
    assign o_frame_type   = r_desc.ftype;
    assign o_frame_length = r_desc.flen;
    assign o_byte_index   = r_idx;
    assign o_data_byte    = has_data ? i_rdata : '0;
    assign o_has_data     = has_data;
    assign o_last         = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_desc <= n_desc;
        r_idx  <= n_idx;
    end

    always_comb begin
        n_state       = r_state;
        n_desc        = r_desc;
        n_idx         = r_idx;
        o_pop         = 1'b0;
        o_re          = 1'b0;
        o_valid       = 1'b0;
        o_status.done = 1'b0;
        o_status.bank = r_desc.bank;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_desc  = i_desc;
                    n_idx   = '0;
                    n_state = B_FETCH;
                end
            end
            B_FETCH: begin
                o_re    = 1'b1;
                n_state = B_SHOW;
            end
            B_SHOW: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (last) begin
                        o_status.done = 1'b1;
                        n_state       = B_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = B_FETCH;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    a_done_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.done |-> o_valid && i_ready && o_last)
        else $error("bank released before last transfer");
    a_data_after_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_re |=> o_valid) else $error("fetched byte not presented");

endmodule

@@ design/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: config registers, parser, queue, release stage.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  byte in  | i_valid / o_ready         | i_rx_byte
//  result   | o_valid / i_ready         | o_frame_type, o_frame_length,
//           |                           | o_byte_index, o_data_byte, o_has_data, o_last
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  The parser takes a received byte whenever i_valid and o_ready are both high.
//  A good frame releases its results one at a time (store read, then output) while the parser
//  keeps taking bytes into the other store bank.
//  The parser stalls (o_ready low) only when the bank it would fill still holds a
//  frame not yet fully released, i.e. both store banks hold checked frames.
//  Reset is synchronous, active low, and restores the register defaults.
//  The result holds steady while i_ready is low; config is always ready.
module serial_frame_receiver (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [srx_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [srx_pkg::BYTE_W-1:0]         o_frame_type,
    output logic [srx_pkg::LEN_W-1:0]          o_frame_length,
    output logic [srx_pkg::IDX_W-1:0]          o_byte_index,
    output logic [srx_pkg::BYTE_W-1:0]         o_data_byte,
    output logic                               o_has_data,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [srx_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [srx_pkg::BYTE_W-1:0]         i_cfg_data
);
    import srx_pkg::*;

    t_cfg         r_cfg;
    t_frame_desc  push_desc;
    t_frame_desc  head_desc;
    t_back_status back_status;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Config writes are registered; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_value      <= SYNC_RST;
            r_cfg.preamble_first  <= PRE1_RST;
            r_cfg.preamble_second <= PRE2_RST;
            r_cfg.payload_limit   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SYNC:  r_cfg.sync_value      <= i_cfg_data;
                CFG_PRE1:  r_cfg.preamble_first  <= i_cfg_data;
                CFG_PRE2:  r_cfg.preamble_second <= i_cfg_data;
                CFG_LIMIT: r_cfg.payload_limit   <= i_cfg_data[LEN_W-1:0];
                default:   r_cfg <= r_cfg;
            endcase
        end
    end

    // Front: header checks, running sum, payload into the free bank.
    srx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_rx_byte (i_rx_byte),
        .o_we      (ram_we),
        .o_waddr   (ram_waddr),
        .o_wdata   (ram_wdata),
        .o_push    (q_push),
        .o_desc    (push_desc),
        .i_full    (q_full),
        .i_back    (back_status)
    );

    // Payload store: two banks of MAX_PAYLOAD bytes, bank is the address MSB.
    srx_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Checked frames waiting for release.
    srx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (push_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_empty (q_empty)
    );

    // Back: walks the stored payload and drives the result channel.
    srx_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc         (head_desc),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_re           (ram_re),
        .o_raddr        (ram_raddr),
        .i_rdata        (ram_rdata),
        .o_status       (back_status),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_data_byte    (o_data_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last)
    );

endmodule
